### rtl/psb_pkg.sv
`default_nettype none
package psb_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACC_X,
    ST_ACC_Y,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_CMP,
    ST_SCL_X,
    ST_SCL_Y,
    ST_POS_X,
    ST_POS_Y,
    ST_BOUNCE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ACC,
    OP_SQ,
    OP_SQRT,
    OP_SCALE,
    OP_POS,
    OP_BOUNCE
  } op_t;

  // Command from the controller to the datapath
  typedef struct packed {
    op_t  op;
    logic sel_y;
    logic start;
    logic clr_flags;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic busy;
    logic over_limit;
  } sts_t;

  localparam int unsigned REG_AREA_WIDTH  = 0;
  localparam int unsigned REG_AREA_HEIGHT = 1;
  localparam int unsigned REG_SPD_LIM     = 2;
  localparam int unsigned REG_STEER_EN    = 3;
  localparam int unsigned REG_START_X     = 4;
  localparam int unsigned REG_START_Y     = 5;
  localparam int unsigned REG_START_VX    = 6;
  localparam int unsigned REG_START_VY    = 7;

  localparam logic REQ_STEP = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = S32_MAX;
    else if (v < -34'sh0_8000_0000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/particle_step_with_bounce.sv
`default_nettype none
// Channel | Direction | Handshake             | Words
// in_     | input     | in_valid / in_ready   | req_type, accel_x/y, delta_time
// out_    | output    | out_valid / out_ready | pos, vel, bounce and limit flags
// cfg_    | input     | cfg_we                | register index, write data
//
// A load word passes through ST_LOAD and ST_DONE; a step without steering through
// ST_POS_X/Y, ST_BOUNCE and ST_DONE. A steered step adds the acceleration, square and
// 32-step square root states, and two 63-step dividers when the speed clamp fires.
// Synchronous active-low reset clears state to zero and registers to defaults.
// A new word is taken only after the previous result has been taken.
module particle_step_with_bounce #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_accel_x,
  input  wire logic [31:0] in_accel_y,
  input  wire logic [15:0] in_delta_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pos_x,
  output logic [31:0]      out_pos_y,
  output logic [31:0]      out_vel_x,
  output logic [31:0]      out_vel_y,
  output logic             out_bounced_x,
  output logic             out_bounced_y,
  output logic             out_speed_limited,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [15:0] area_width_r, area_height_r;
  logic [30:0] spd_lim_r;
  logic        steer_en_r;
  logic [31:0] start_x_r, start_y_r, start_vx_r, start_vy_r;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_width_r <= 16'd800; area_height_r <= 16'd600;
      spd_lim_r <= 31'd6553600; steer_en_r <= 1'b0;
      start_x_r <= '0; start_y_r <= '0; start_vx_r <= '0; start_vy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        3'(psb_pkg::REG_AREA_WIDTH):  area_width_r  <= cfg_data[15:0];
        3'(psb_pkg::REG_AREA_HEIGHT): area_height_r <= cfg_data[15:0];
        3'(psb_pkg::REG_SPD_LIM):     spd_lim_r     <= cfg_data[30:0];
        3'(psb_pkg::REG_STEER_EN):    steer_en_r    <= cfg_data[0];
        3'(psb_pkg::REG_START_X):     start_x_r     <= cfg_data;
        3'(psb_pkg::REG_START_Y):     start_y_r     <= cfg_data;
        3'(psb_pkg::REG_START_VX):    start_vx_r    <= cfg_data;
        3'(psb_pkg::REG_START_VY):    start_vy_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  psb_pkg::cmd_t cmd;
  psb_pkg::sts_t sts;

  psb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .req_type(in_req_type),
    .steer_en(steer_en_r), .out_valid, .out_ready, .cmd, .sts
  );

  psb_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk, .rst_n, .cmd, .sts,
    .in_accel_x, .in_accel_y, .in_delta_time,
    .in_take(in_valid && in_ready),
    .area_width(area_width_r), .area_height(area_height_r),
    .spd_lim(spd_lim_r),
    .start_x(start_x_r), .start_y(start_y_r),
    .start_vx(start_vx_r), .start_vy(start_vy_r),
    .pos_x(out_pos_x), .pos_y(out_pos_y),
    .vel_x(out_vel_x), .vel_y(out_vel_y),
    .bounced_x(out_bounced_x), .bounced_y(out_bounced_y),
    .speed_limited(out_speed_limited)
  );

endmodule
`default_nettype wire

### rtl/psb_ctrl.sv
`default_nettype none
module psb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          req_type,
  input  wire logic          steer_en,
  output logic               out_valid,
  input  wire logic          out_ready,
  output psb_pkg::cmd_t      cmd,
  input  wire psb_pkg::sts_t sts
);

  psb_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  // Take a new word once the previous result has left the output register
  assign in_ready  = (state_r == psb_pkg::ST_IDLE) && !out_valid_r;

  // Sequence one word through the shared units
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{op: psb_pkg::OP_NONE, sel_y: 1'b0, start: 1'b0, clr_flags: 1'b0};
    case (state_r)
      psb_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.clr_flags = 1'b1;
          if (req_type == psb_pkg::REQ_LOAD) state_nxt = psb_pkg::ST_LOAD;
          else if (steer_en) state_nxt = psb_pkg::ST_ACC_X;
          else state_nxt = psb_pkg::ST_POS_X;
        end
      end
      psb_pkg::ST_LOAD: begin
        cmd.op    = psb_pkg::OP_LOAD;
        state_nxt = psb_pkg::ST_DONE;
      end
      psb_pkg::ST_ACC_X: begin
        cmd.op = psb_pkg::OP_ACC;
        state_nxt = psb_pkg::ST_ACC_Y;
      end
      psb_pkg::ST_ACC_Y: begin
        cmd.op = psb_pkg::OP_ACC; cmd.sel_y = 1'b1;
        state_nxt = psb_pkg::ST_SQ_X;
      end
      psb_pkg::ST_SQ_X: begin
        cmd.op = psb_pkg::OP_SQ;
        state_nxt = psb_pkg::ST_SQ_Y;
      end
      psb_pkg::ST_SQ_Y: begin
        cmd.op = psb_pkg::OP_SQ; cmd.sel_y = 1'b1; cmd.start = 1'b1;
        state_nxt = psb_pkg::ST_SQRT;
      end
      psb_pkg::ST_SQRT: begin
        cmd.op = psb_pkg::OP_SQRT;
        if (!sts.busy) state_nxt = psb_pkg::ST_CMP;
      end
      psb_pkg::ST_CMP: begin
        if (sts.over_limit) begin
          cmd.op = psb_pkg::OP_SCALE; cmd.start = 1'b1;
          state_nxt = psb_pkg::ST_SCL_X;
        end else begin
          state_nxt = psb_pkg::ST_POS_X;
        end
      end
      psb_pkg::ST_SCL_X: begin
        cmd.op = psb_pkg::OP_SCALE;
        if (!sts.busy) begin
          cmd.sel_y = 1'b1; cmd.start = 1'b1;
          state_nxt = psb_pkg::ST_SCL_Y;
        end
      end
      psb_pkg::ST_SCL_Y: begin
        cmd.op = psb_pkg::OP_SCALE; cmd.sel_y = 1'b1;
        if (!sts.busy) state_nxt = psb_pkg::ST_POS_X;
      end
      psb_pkg::ST_POS_X: begin
        cmd.op = psb_pkg::OP_POS;
        state_nxt = psb_pkg::ST_POS_Y;
      end
      psb_pkg::ST_POS_Y: begin
        cmd.op = psb_pkg::OP_POS; cmd.sel_y = 1'b1;
        state_nxt = psb_pkg::ST_BOUNCE;
      end
      psb_pkg::ST_BOUNCE: begin
        cmd.op = psb_pkg::OP_BOUNCE;
        state_nxt = psb_pkg::ST_DONE;
      end
      psb_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = psb_pkg::ST_IDLE;
      end
      default: state_nxt = psb_pkg::ST_IDLE;
    endcase
  end

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("input taken while result pending");
  a_done_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == psb_pkg::ST_DONE |=> out_valid_r) else $error("result not presented");
  a_scale_only_steer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psb_pkg::ST_IDLE && in_valid && in_ready && !steer_en)
      |=> state_r != psb_pkg::ST_ACC_X) else $error("steering path without enable");

endmodule
`default_nettype wire

### rtl/psb_dpath.sv
`default_nettype none
module psb_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire psb_pkg::cmd_t       cmd,
  output psb_pkg::sts_t            sts,
  input  wire logic signed [31:0]  in_accel_x,
  input  wire logic signed [31:0]  in_accel_y,
  input  wire logic [15:0]         in_delta_time,
  input  wire logic                in_take,
  input  wire logic [15:0]         area_width,
  input  wire logic [15:0]         area_height,
  input  wire logic [30:0]         spd_lim,
  input  wire logic signed [31:0]  start_x,
  input  wire logic signed [31:0]  start_y,
  input  wire logic signed [31:0]  start_vx,
  input  wire logic signed [31:0]  start_vy,
  output logic signed [31:0]       pos_x,
  output logic signed [31:0]       pos_y,
  output logic signed [31:0]       vel_x,
  output logic signed [31:0]       vel_y,
  output logic                     bounced_x,
  output logic                     bounced_y,
  output logic                     speed_limited
);

  localparam int LIM_W = 16 + FRAC_BITS + 1;
  localparam logic [FRAC_BITS-1:0] FMASK = {FRAC_BITS{1'b1}};

  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic signed [31:0] ax_r, ay_r;
  logic [15:0]        dt_r;
  logic               bx_r, by_r, lim_r;
  logic [63:0]        sumsq_r;

  // Isqrt state: one result bit per cycle
  logic [63:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  sq_cnt_r;
  // Restoring divider state: one quotient bit per cycle
  logic [62:0] dvd_r;
  logic [31:0] dvs_r;
  logic [31:0] drem_r;
  logic [62:0] quo_r;
  logic [5:0]  dv_cnt_r;
  logic        busy_r;
  logic        neg_r;

  // Shared multiply of |p| by dt, floor shift, saturate
  logic signed [31:0] mul_p;
  logic [31:0]        mul_mag;
  logic [47:0]        mul_m;
  logic [47:0]        mul_q;
  logic signed [33:0] mul_s;
  logic signed [31:0] mul_res;

  always_comb begin
    case (cmd.op)
      psb_pkg::OP_ACC: mul_p = cmd.sel_y ? ay_r : ax_r;
      default:         mul_p = cmd.sel_y ? vel_y_r : vel_x_r;
    endcase
    mul_mag = mul_p[31] ? 32'(-mul_p) : mul_p;
    mul_m   = 48'(mul_mag) * 48'(dt_r);
    if (!mul_p[31]) mul_q = mul_m >> FRAC_BITS;
    else            mul_q = (mul_m + 48'(FMASK)) >> FRAC_BITS;
    // quotient < 2^32 always since |p| <= 2^31 and dt < 2^16
    if (!mul_p[31]) mul_s = (mul_q[47:33] != '0) ? 34'sh0_7FFF_FFFF : 34'(mul_q[32:0]);
    else            mul_s = (mul_q[47:33] != '0) ? -34'sh0_8000_0000 : -34'(mul_q[32:0]);
    mul_res = psb_pkg::sat34(mul_s);
  end

  // Add the product to state
  logic signed [31:0] add_a, add_res;
  always_comb begin
    case (cmd.op)
      psb_pkg::OP_ACC: add_a = cmd.sel_y ? vel_y_r : vel_x_r;
      default:         add_a = cmd.sel_y ? pos_y_r : pos_x_r;
    endcase
    add_res = psb_pkg::sat34(34'(add_a) + 34'(mul_res));
  end

  // Square of one velocity component
  logic [31:0] sq_mag;
  logic [63:0] sq_val;
  always_comb begin
    sq_mag = cmd.sel_y ? (vel_y_r[31] ? 32'(-vel_y_r) : vel_y_r)
                       : (vel_x_r[31] ? 32'(-vel_x_r) : vel_x_r);
    sq_val = 64'(sq_mag) * 64'(sq_mag);
  end

  // Divider step
  logic [32:0] dv_try;
  assign dv_try = {drem_r, dvd_r[62]} - {1'b0, dvs_r};

  // Edge limits
  logic signed [LIM_W:0] lim_x, lim_y;
  assign lim_x = (LIM_W+1)'({area_width, {FRAC_BITS{1'b0}}});
  assign lim_y = (LIM_W+1)'({area_height, {FRAC_BITS{1'b0}}});

  function automatic logic [31:0] neg_sat(input logic signed [31:0] v);
    return (v == psb_pkg::S32_MIN) ? psb_pkg::S32_MAX : 32'(-v);
  endfunction

  logic [63:0] rem_src;
  logic [1:0]  pair;
  logic [33:0] rtry;
  always_comb begin
    pair    = sumsq_r[63:62];
    rem_src = {rem_r[61:0], pair};
    rtry    = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0; pos_y_r <= '0; vel_x_r <= '0; vel_y_r <= '0;
      bx_r <= 1'b0; by_r <= 1'b0; lim_r <= 1'b0; busy_r <= 1'b0;
    end else begin
      if (in_take) begin
        ax_r <= in_accel_x; ay_r <= in_accel_y; dt_r <= in_delta_time;
      end
      if (cmd.clr_flags) begin
        bx_r <= 1'b0; by_r <= 1'b0; lim_r <= 1'b0;
      end
      case (cmd.op)
        psb_pkg::OP_LOAD: begin
          pos_x_r <= start_x; pos_y_r <= start_y;
          vel_x_r <= start_vx; vel_y_r <= start_vy;
        end
        psb_pkg::OP_ACC: begin
          if (cmd.sel_y) vel_y_r <= add_res; else vel_x_r <= add_res;
        end
        psb_pkg::OP_POS: begin
          if (cmd.sel_y) pos_y_r <= add_res; else pos_x_r <= add_res;
        end
        psb_pkg::OP_SQ: begin
          if (cmd.sel_y) sumsq_r <= sumsq_r + sq_val; else sumsq_r <= sq_val;
          if (cmd.start) begin
            rem_r <= '0; root_r <= '0; sq_cnt_r <= 6'd32; busy_r <= 1'b1;
          end
        end
        psb_pkg::OP_SQRT: begin
          // Digit-by-digit root, two radicand bits per cycle
          if (busy_r) begin
            if (rem_src >= 64'(rtry)) begin
              rem_r  <= rem_src - 64'(rtry);
              root_r <= {root_r[30:0], 1'b1};
            end else begin
              rem_r  <= rem_src;
              root_r <= {root_r[30:0], 1'b0};
            end
            sumsq_r  <= {sumsq_r[61:0], 2'b00};
            sq_cnt_r <= sq_cnt_r - 6'd1;
            if (sq_cnt_r == 6'd1) busy_r <= 1'b0;
          end
        end
        psb_pkg::OP_SCALE: begin
          if (cmd.start) begin
            // |v| times the speed limit, then divide by the root
            neg_r  <= cmd.sel_y ? vel_y_r[31] : vel_x_r[31];
            dvd_r  <= 63'(sq_mag) * 63'(spd_lim);
            dvs_r  <= root_r;
            drem_r <= '0;
            quo_r  <= '0;
            dv_cnt_r <= 6'd63;
            busy_r <= 1'b1;
            lim_r  <= 1'b1;
          end else if (busy_r) begin
            if (!dv_try[32]) begin
              drem_r <= dv_try[31:0];
              quo_r  <= {quo_r[61:0], 1'b1};
            end else begin
              drem_r <= {drem_r[30:0], dvd_r[62]};
              quo_r  <= {quo_r[61:0], 1'b0};
            end
            dvd_r    <= {dvd_r[61:0], 1'b0};
            dv_cnt_r <= dv_cnt_r - 6'd1;
            if (dv_cnt_r == 6'd1) begin
              busy_r <= 1'b0;
              // quotient <= |v| fits in 32 bits
              if (cmd.sel_y) vel_y_r <= neg_r ? 32'(-{quo_r[30:0], !dv_try[32]})
                                              : 32'({quo_r[30:0], !dv_try[32]});
              else           vel_x_r <= neg_r ? 32'(-{quo_r[30:0], !dv_try[32]})
                                              : 32'({quo_r[30:0], !dv_try[32]});
            end
          end
        end
        psb_pkg::OP_BOUNCE: begin
          if ((LIM_W+1)'(pos_x_r) > lim_x || pos_x_r[31]) begin
            bx_r <= 1'b1; vel_x_r <= neg_sat(vel_x_r);
            pos_x_r <= pos_x_r[31] ? '0 : 32'(lim_x);
          end
          if ((LIM_W+1)'(pos_y_r) > lim_y || pos_y_r[31]) begin
            by_r <= 1'b1; vel_y_r <= neg_sat(vel_y_r);
            pos_y_r <= pos_y_r[31] ? '0 : 32'(lim_y);
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.busy       = busy_r;
  assign sts.over_limit = {1'b0, root_r} > {2'b00, spd_lim};

  assign pos_x = pos_x_r; assign pos_y = pos_y_r;
  assign vel_x = vel_x_r; assign vel_y = vel_y_r;
  assign bounced_x = bx_r; assign bounced_y = by_r; assign speed_limited = lim_r;

  a_bounce_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == psb_pkg::OP_BOUNCE && pos_x_r[31]) |=> (pos_x_r == 0 && bx_r))
    else $error("negative x not clamped");
  a_busy_only_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cmd.op != psb_pkg::OP_SQRT && cmd.op != psb_pkg::OP_SCALE) |-> 0)
    else $error("iterative unit busy outside its phase");
  a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == psb_pkg::OP_SCALE && cmd.start) |=> lim_r)
    else $error("speed clamp not flagged");

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int FRAC = 16;
  localparam longint LIMIT_CYCLES = 2000000;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 11;
  localparam int WORDS_PER_PHASE = 50;

  typedef struct {
    logic        req;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [15:0] dt;
  } step_word_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic        bx;
    logic        by;
    logic        lim;
  } particle_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [31:0] in_accel_x = '0;
  logic [31:0] in_accel_y = '0;
  logic [15:0] in_delta_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic        out_bounced_x, out_bounced_y, out_speed_limited;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  particle_step_with_bounce u_top (.*);

  initial forever #5 clk = ~clk;

  // Particle state and register copies
  longint          p_x, p_y, v_x, v_y;
  longint unsigned area_w, area_h, speed_cap;
  bit              steer_on;
  longint          st_x, st_y, st_vx, st_vy;

  step_word_t pending_words[$];
  particle_t  expected_states[$];
  int         errors = 0;
  longint     cycles = 0;
  bit         in_fire = 0, out_fire = 0;
  bit         hold_req = 0;

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // (p * dt) >> FRAC, rounded toward minus infinity, saturated
  function automatic longint mul_dt(input longint p, input longint unsigned dt);
    longint unsigned m;
    m = longint'(p < 0 ? -p : p) * dt;
    if (p >= 0) return sat32(longint'(m >> FRAC));
    return sat32(-longint'((m + (64'd1 << FRAC) - 1) >> FRAC));
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint scale_to_cap(input longint v, input longint unsigned num,
                                          input longint unsigned den);
    longint unsigned q;
    q = (longint'(v < 0 ? -v : v) * num) / den;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Clamp a coordinate to [0, size] and reverse its velocity on exit
  function automatic bit clamp_axis(inout longint pos, inout longint vel,
                                    input longint unsigned size);
    longint lim_pos;
    lim_pos = longint'(size << FRAC);
    if (pos > lim_pos || pos < 0) begin
      vel = sat32(-vel);
      pos = (pos > lim_pos) ? lim_pos : 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic particle_t advance_particle(input step_word_t w);
    particle_t       r;
    longint          ax, ay;
    longint unsigned dt, mx, my, mg;
    r.bx = 0;
    r.by = 0;
    r.lim = 0;
    if (w.req == psb_pkg::REQ_LOAD) begin
      p_x = st_x;
      p_y = st_y;
      v_x = st_vx;
      v_y = st_vy;
    end else begin
      ax = longint'($signed(w.ax));
      ay = longint'($signed(w.ay));
      dt = w.dt;
      if (steer_on) begin
        v_x = sat32(v_x + mul_dt(ax, dt));
        v_y = sat32(v_y + mul_dt(ay, dt));
        mx = v_x < 0 ? -v_x : v_x;
        my = v_y < 0 ? -v_y : v_y;
        mg = floor_root(mx * mx + my * my);
        if (mg > speed_cap) begin
          v_x = scale_to_cap(v_x, speed_cap, mg);
          v_y = scale_to_cap(v_y, speed_cap, mg);
          r.lim = 1;
        end
      end
      p_x = sat32(p_x + mul_dt(v_x, dt));
      p_y = sat32(p_y + mul_dt(v_y, dt));
      r.bx = clamp_axis(p_x, v_x, area_w);
      r.by = clamp_axis(p_y, v_y, area_h);
    end
    r.px = p_x[31:0];
    r.py = p_y[31:0];
    r.vx = v_x[31:0];
    r.vy = v_y[31:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Sample handshakes, predict on input words, compare on output words
  always @(posedge clk) begin
    particle_t e;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at %0t", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      in_fire <= rst_n && in_valid && in_ready;
      out_fire <= rst_n && out_valid && out_ready;
      if (rst_n && in_valid && in_ready)
        expected_states.push_back(advance_particle('{in_req_type, in_accel_x, in_accel_y,
                                                     in_delta_time}));
      if (rst_n && out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          $display("%0t unexpected word pos %h %h", $time, out_pos_x, out_pos_y);
          errors++;
        end else begin
          e = expected_states.pop_front();
          check_field("pos_x", e.px, out_pos_x);
          check_field("pos_y", e.py, out_pos_y);
          check_field("vel_x", e.vx, out_vel_x);
          check_field("vel_y", e.vy, out_vel_y);
          check_field("bounced_x", 32'(e.bx), 32'(out_bounced_x));
          check_field("bounced_y", 32'(e.by), 32'(out_bounced_y));
          check_field("speed_limited", 32'(e.lim), 32'(out_speed_limited));
        end
      end
    end
  end

  // Sender: hold each word until taken, then idle a drawn number of cycles
  int gap_left = 0;
  always @(negedge clk) begin
    step_word_t w;
    logic       nxt_valid;
    nxt_valid = in_valid;
    if (rst_n && (!in_valid || in_fire)) begin
      nxt_valid = 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_req_type <= w.req;
        in_accel_x <= w.ax;
        in_accel_y <= w.ay;
        in_delta_time <= w.dt;
        nxt_valid = 1;
        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end
    end
    in_valid <= nxt_valid;
  end

  // Receiver: random stalls per word, plus one long hold-off on request
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 0;
    end
    if (out_fire) stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      3'(psb_pkg::REG_AREA_WIDTH):  area_w = d[15:0];
      3'(psb_pkg::REG_AREA_HEIGHT): area_h = d[15:0];
      3'(psb_pkg::REG_SPD_LIM):     speed_cap = d[30:0];
      3'(psb_pkg::REG_STEER_EN):    steer_on = d[0];
      3'(psb_pkg::REG_START_X):     st_x = longint'($signed(d));
      3'(psb_pkg::REG_START_Y):     st_y = longint'($signed(d));
      3'(psb_pkg::REG_START_VX):    st_vx = longint'($signed(d));
      3'(psb_pkg::REG_START_VY):    st_vy = longint'($signed(d));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic write_all(input logic [15:0] w, input logic [15:0] h, input logic [30:0] cap,
                           input logic steer, input logic [31:0] sx, input logic [31:0] sy,
                           input logic [31:0] svx, input logic [31:0] svy);
    // upper bits beyond each register's width are random
    write_reg(3'(psb_pkg::REG_AREA_WIDTH), ($urandom & 32'hFFFF_0000) | w);
    write_reg(3'(psb_pkg::REG_AREA_HEIGHT), ($urandom & 32'hFFFF_0000) | h);
    write_reg(3'(psb_pkg::REG_SPD_LIM), ($urandom & 32'h8000_0000) | cap);
    write_reg(3'(psb_pkg::REG_STEER_EN), ($urandom & 32'hFFFF_FFFE) | steer);
    write_reg(3'(psb_pkg::REG_START_X), sx);
    write_reg(3'(psb_pkg::REG_START_Y), sy);
    write_reg(3'(psb_pkg::REG_START_VX), svx);
    write_reg(3'(psb_pkg::REG_START_VY), svy);
  endtask

  task automatic push_word(input logic req, input logic [31:0] ax, input logic [31:0] ay,
                           input logic [15:0] dt);
    pending_words.push_back('{req, ax, ay, dt});
  endtask

  // Wait until every word is taken and every result checked
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_states.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_accel();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: case ($urandom_range(0, 3))
           0: return psb_pkg::S32_MIN;
           1: return psb_pkg::S32_MAX;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(0, 1 << 23) - (1 << 22);
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 25) - (1 << 24);
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return 16'h0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [15:0] w, h;
    logic [30:0] cap;
    area_w = 800;
    area_h = 600;
    speed_cap = 6553600;
    steer_on = 0;
    st_x = 0; st_y = 0; st_vx = 0; st_vy = 0;
    p_x = 0; p_y = 0; v_x = 0; v_y = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Defaults straight out of reset: idle particle, zero and full time step
    push_word(psb_pkg::REQ_STEP, psb_pkg::S32_MAX, psb_pkg::S32_MIN, 16'h0);
    push_word(psb_pkg::REQ_STEP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF);
    drain();

    // Steering off, most negative velocity: exit left, reversed to saturated max
    write_all(16'd800, 16'd600, 31'd6553600, 1'b0, 32'd10 << 16, 32'd20 << 16,
              psb_pkg::S32_MIN, psb_pkg::S32_MAX);
    push_word(psb_pkg::REQ_LOAD, $urandom, $urandom, 16'($urandom));
    push_word(psb_pkg::REQ_STEP, 32'h0, 32'h0, 16'hFFFF);
    push_word(psb_pkg::REQ_STEP, psb_pkg::S32_MAX, psb_pkg::S32_MIN, 16'd1);
    drain();

    // Zero speed limit with steering on; zero size window
    write_all(16'd0, 16'd0, 31'd0, 1'b1, 32'd0, 32'd0, 32'd3 << 16, 32'hFFFD_0000);
    push_word(psb_pkg::REQ_LOAD, 32'h0, 32'h0, 16'h0);
    push_word(psb_pkg::REQ_STEP, psb_pkg::S32_MAX, psb_pkg::S32_MIN, 16'hFFFF);
    push_word(psb_pkg::REQ_STEP, 32'hFFFF_FFFF, 32'h1, 16'd1);
    push_word(psb_pkg::REQ_STEP, 32'h0, 32'h0, 16'h0);
    drain();

    // Largest window (edge beyond 32-bit range) and largest speed limit
    write_all(16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 32'h7FF0_0000, 32'h0010_0000,
              psb_pkg::S32_MAX, psb_pkg::S32_MIN);
    push_word(psb_pkg::REQ_LOAD, 32'h0, 32'h0, 16'h0);
    push_word(psb_pkg::REQ_STEP, psb_pkg::S32_MAX, psb_pkg::S32_MIN, 16'hFFFF);
    push_word(psb_pkg::REQ_STEP, psb_pkg::S32_MAX, psb_pkg::S32_MAX, 16'hFFFF);
    push_word(psb_pkg::REQ_STEP, psb_pkg::S32_MIN, psb_pkg::S32_MIN, 16'hFFFF);
    push_word(psb_pkg::REQ_STEP, 32'hFFFF_FFFF, 32'h0, 16'h8000);
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
      h = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
      case ($urandom_range(0, 5))
        0: cap = 31'd0;
        1: cap = 31'h7FFF_FFFF;
        default: cap = 31'($urandom_range(1 << 16, 1 << 24));
      endcase
      if (ph == 0) begin
        w = 16'd1;
        h = 16'hFFFF;
      end
      write_all(w, h, cap, $urandom_range(0, 3) != 0,
                $urandom_range(0, w) << 16, $urandom_range(0, h) << 16,
                rand_vel(), rand_vel());
      push_word(psb_pkg::REQ_LOAD, $urandom, $urandom, 16'($urandom));
      for (int i = 1; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 19) == 0)
          push_word(psb_pkg::REQ_LOAD, $urandom, $urandom, 16'($urandom));
        else
          push_word(psb_pkg::REQ_STEP, rand_accel(), rand_accel(), rand_dt());
      end
      // long receiver hold-off while the sender keeps offering
      if (ph == 2) begin
        @(posedge clk);
        hold_req = 1;
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
